// File: sv/msrr_pkg.sv
// msrr_pkg: widths, codes, control structs and helpers for the motor soft ramp controller
// no dependencies; imported by every module of the block

package msrr_pkg;

  localparam int SPEED_W    = 10;
  localparam int DUR_W      = 14;
  localparam int DUTY_W     = 10;
  localparam int STEP_W     = 8;
  localparam int REQ_W      = 4;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [SPEED_W-1:0] MAX_SPEED   = 10'd1000;
  localparam logic [SPEED_W-1:0] RAMP_STEP   = 10'd5;
  localparam logic [DUR_W-1:0]   ELAPSED_MAX = 14'd16383;

  localparam logic [DUR_W-1:0]   RST_RAMP_DUR   = 14'd4000;
  localparam logic [DUTY_W-1:0]  RST_DUTY_MIN   = 10'd500;
  localparam logic [DUTY_W-1:0]  RST_DUTY_MAX   = 10'd900;
  localparam logic [SPEED_W-1:0] RST_SPEED_INC  = 10'd50;
  localparam logic [SPEED_W-1:0] RST_INIT_SPEED = 10'd400;
  localparam logic [SPEED_W-1:0] RST_REV_SPEED  = 10'd200;

  // d / 5 as (d * 205) >> 10, exact below 1024
  localparam int                  DIV5_MUL_W = 8;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 8'd205;
  localparam int                  DIV5_SHIFT = 10;

  // p / 999 as (p * 1049) >> 20, low by at most one
  localparam int                  PROD_W      = 2 * SPEED_W;
  localparam int                  RECIP_W     = 11;
  localparam logic [RECIP_W-1:0]  DUTY_RECIP  = 11'd1049;
  localparam int                  DUTY_SHIFT  = 20;
  localparam logic [SPEED_W-1:0]  DUTY_SPAN   = 10'd999;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE = 2'd0,
    MODE_DOWN = 2'd1,
    MODE_UP   = 2'd2
  } mode_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK      = 4'd0,
    REQ_START     = 4'd1,
    REQ_REVERSE   = 4'd2,
    REQ_UP        = 4'd3,
    REQ_DOWN      = 4'd4,
    REQ_STOP      = 4'd5,
    REQ_SET       = 4'd6,
    REQ_OFF       = 4'd7,
    REQ_LONGPRESS = 4'd8
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAMP_DUR   = 3'd0,
    CFG_DUTY_MIN   = 3'd1,
    CFG_DUTY_MAX   = 3'd2,
    CFG_SPEED_INC  = 3'd3,
    CFG_INIT_SPEED = 3'd4,
    CFG_REV_SPEED  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic apply;
    logic calc_steps;
    logic duty_start;
    logic delay_one;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic retime;
    logic steps_zero;
    logic div_busy;
    logic duty_valid;
  } sts_t;

  function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W:0] v);
    return (v > {1'b0, MAX_SPEED}) ? MAX_SPEED : v[SPEED_W-1:0];
  endfunction

endpackage

// File: sv/msrr_chan_if.sv
// msrr channel interfaces: command input, result output and register write port
// depends on msrr_pkg for field widths

interface msrr_in_if import msrr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [SPEED_W-1:0] new_speed;

  modport source (output valid, output req_type, output new_speed, input ready);
  modport sink   (input valid, input req_type, input new_speed, output ready);
endinterface

interface msrr_out_if import msrr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty;
  logic               clockwise;
  logic               running;
  logic [SPEED_W-1:0] speed_now;
  logic [MODE_W-1:0]  ramp_mode;

  modport source (output valid, output duty, output clockwise, output running,
                  output speed_now, output ramp_mode, input ready);
  modport sink   (input valid, input duty, input clockwise, input running,
                  input speed_now, input ramp_mode, output ready);
endinterface

interface msrr_cfg_if import msrr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/msrr_div.sv
// msrr_div: restoring divider, one quotient bit per cycle, for the ramp step delay
// depends on msrr_pkg

module msrr_div import msrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DUR_W-1:0]  dividend,
  input  logic [STEP_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DUR_W-1:0]  quot
);

  localparam int CNT_W = $clog2(DUR_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DUR_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DUR_W-1:0]  quo_r;
  logic [STEP_W-1:0] rem_r;
  logic [STEP_W-1:0] dvs_r;
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DUR_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      quo_r <= {quo_r[DUR_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;

endmodule

// File: sv/msrr_duty.sv
// msrr_duty: three-stage pipeline mapping logical speed onto the pwm duty range
// depends on msrr_pkg

module msrr_duty import msrr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SPEED_W-1:0] speed,
  input  logic [DUTY_W-1:0]  duty_lo,
  input  logic [DUTY_W-1:0]  duty_hi,
  output logic               valid,
  output logic [DUTY_W-1:0]  duty
);

  logic                     s1_v_r, s2_v_r, valid_r;
  logic [PROD_W-1:0]        p1_r, p2_r;
  logic                     neg1_r, neg2_r, zero1_r, zero2_r;
  logic [RECIP_W-1:0]       q0_r;
  logic [DUTY_W-1:0]        duty_r;

  logic [DUTY_W:0]          span;
  logic [DUTY_W-1:0]        span_mag;
  logic [SPEED_W-1:0]       sm1;
  logic [PROD_W+RECIP_W-1:0] t_full;
  logic [PROD_W:0]          qm;
  logic [PROD_W:0]          rem;
  logic [RECIP_W-1:0]       q;
  logic [DUTY_W+1:0]        v;

  assign span     = {1'b0, duty_hi} - {1'b0, duty_lo};
  assign span_mag = span[DUTY_W] ? DUTY_W'(-span) : span[DUTY_W-1:0];
  assign sm1      = speed - 1'b1;
  assign t_full   = {{RECIP_W{1'b0}}, p1_r} * {{PROD_W{1'b0}}, DUTY_RECIP};
  assign qm       = (PROD_W+1)'({{(PROD_W+1-RECIP_W){1'b0}}, q0_r} *
                                {{(PROD_W+1-SPEED_W){1'b0}}, DUTY_SPAN});
  assign rem      = {1'b0, p2_r} - qm;
  assign q        = q0_r + RECIP_W'(rem >= {{(PROD_W+1-SPEED_W){1'b0}}, DUTY_SPAN});
  assign v        = neg2_r ? ({2'b0, duty_lo} - {1'b0, q}) : ({2'b0, duty_lo} + {1'b0, q});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      s1_v_r <= start;
      s2_v_r <= s1_v_r;
      if (start) begin
        valid_r <= 1'b0;
      end else if (s2_v_r) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_r    <= {{SPEED_W{1'b0}}, sm1} * {{SPEED_W{1'b0}}, span_mag};
    neg1_r  <= span[DUTY_W];
    zero1_r <= speed == '0;
    p2_r    <= p1_r;
    neg2_r  <= neg1_r;
    zero2_r <= zero1_r;
    q0_r    <= t_full[DUTY_SHIFT +: RECIP_W];
    if (s2_v_r) begin
      duty_r <= zero2_r ? '0 : v[DUTY_W-1:0];
    end
  end

  assign valid = valid_r;
  assign duty  = duty_r;

endmodule

// File: sv/msrr_dp.sv
// msrr_dp: ramp state, command decode, register file, step-delay and duty units
// depends on msrr_pkg, msrr_div and msrr_duty

module msrr_dp import msrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [SPEED_W-1:0]    new_speed,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [DUTY_W-1:0]     out_duty,
  output logic                  out_clockwise,
  output logic                  out_running,
  output logic [SPEED_W-1:0]    out_speed_now,
  output logic [MODE_W-1:0]     out_ramp_mode
);

  logic [DUR_W-1:0]   ramp_dur_r;
  logic [DUTY_W-1:0]  duty_min_r, duty_max_r;
  logic [SPEED_W-1:0] speed_inc_r, init_speed_r, rev_speed_r;

  mode_t              mode_r, mode_nxt;
  logic [SPEED_W-1:0] cur_r, cur_nxt, tgt_r, tgt_nxt, set_r, set_nxt;
  logic [DUR_W-1:0]   delay_r, elapsed_r, elapsed_nxt;
  logic               rev_r, rev_nxt, dir_r, dir_nxt, run_r, run_nxt;
  logic               retime_r, retime_nxt;
  logic [STEP_W-1:0]  steps_r;

  logic [DUTY_W-1:0]  out_duty_r;
  logic               out_cw_r, out_run_r;
  logic [SPEED_W-1:0] out_speed_r;
  logic [MODE_W-1:0]  out_mode_r;

  logic [SPEED_W-1:0] floor_spd, rev_cl, cur_step, spd_sel;
  logic [SPEED_W:0]   sum_inc, floor_sum, up_n, tgt_p5;
  logic [DUR_W-1:0]   el_inc;
  logic [SPEED_W-1:0] spd_gap;
  logic [SPEED_W+DIV5_MUL_W-1:0] dist_prod;
  logic [STEP_W-1:0]  steps_calc;

  logic               div_busy, div_done;
  logic [DUR_W-1:0]   div_quot;
  logic               duty_valid;
  logic [DUTY_W-1:0]  duty_val;

  function automatic mode_t aim_mode(input logic [SPEED_W-1:0] tgt,
                                     input logic [SPEED_W-1:0] cur,
                                     input mode_t              if_equal);
    if (tgt > cur) begin
      return MODE_UP;
    end else if (tgt < cur) begin
      return MODE_DOWN;
    end
    return if_equal;
  endfunction

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_dur_r   <= RST_RAMP_DUR;
      duty_min_r   <= RST_DUTY_MIN;
      duty_max_r   <= RST_DUTY_MAX;
      speed_inc_r  <= RST_SPEED_INC;
      init_speed_r <= RST_INIT_SPEED;
      rev_speed_r  <= RST_REV_SPEED;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RAMP_DUR:   ramp_dur_r   <= cfg_data[DUR_W-1:0];
        CFG_DUTY_MIN:   duty_min_r   <= cfg_data[DUTY_W-1:0];
        CFG_DUTY_MAX:   duty_max_r   <= cfg_data[DUTY_W-1:0];
        CFG_SPEED_INC:  speed_inc_r  <= cfg_data[SPEED_W-1:0];
        CFG_INIT_SPEED: init_speed_r <= cfg_data[SPEED_W-1:0];
        CFG_REV_SPEED:  rev_speed_r  <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign floor_spd = clamp_speed({1'b0, init_speed_r});
  assign rev_cl    = clamp_speed({1'b0, rev_speed_r});
  assign sum_inc   = {1'b0, set_r} + {1'b0, speed_inc_r};
  assign floor_sum = {1'b0, speed_inc_r} + {1'b0, floor_spd};
  assign up_n      = {1'b0, cur_r} + {1'b0, RAMP_STEP};
  assign tgt_p5    = {1'b0, tgt_r} + {1'b0, RAMP_STEP};
  assign el_inc    = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;

  // item decode
  always_comb begin
    mode_nxt    = mode_r;
    cur_nxt     = cur_r;
    tgt_nxt     = tgt_r;
    set_nxt     = set_r;
    elapsed_nxt = elapsed_r;
    rev_nxt     = rev_r;
    dir_nxt     = dir_r;
    run_nxt     = run_r;
    retime_nxt  = 1'b0;
    cur_step    = cur_r;
    spd_sel     = set_r;
    unique case (req_t'(req_type)) inside
      REQ_TICK: begin
        elapsed_nxt = el_inc;
        if (mode_r != MODE_IDLE && el_inc > delay_r) begin
          elapsed_nxt = '0;
          if (mode_r == MODE_UP) begin
            cur_step = (up_n < {1'b0, tgt_r}) ? up_n[SPEED_W-1:0] : tgt_r;
          end else begin
            cur_step = ({1'b0, cur_r} > tgt_p5) ? cur_r - RAMP_STEP : tgt_r;
          end
          cur_nxt = cur_step;
          if (cur_step == tgt_r) begin
            if (rev_r) begin
              dir_nxt    = ~dir_r;
              rev_nxt    = 1'b0;
              run_nxt    = 1'b1;
              tgt_nxt    = set_r;
              retime_nxt = 1'b1;
              mode_nxt   = aim_mode(set_r, cur_step, MODE_UP);
            end else begin
              mode_nxt = MODE_IDLE;
              if (cur_step == '0) begin
                run_nxt = 1'b0;
                set_nxt = floor_spd;
              end
            end
          end
        end
      end
      REQ_START: begin
        if (!run_r) begin
          tgt_nxt    = set_r;
          retime_nxt = 1'b1;
          mode_nxt   = aim_mode(set_r, cur_r, MODE_UP);
          run_nxt    = 1'b1;
        end
      end
      REQ_REVERSE: begin
        if (run_r) begin
          rev_nxt    = 1'b1;
          tgt_nxt    = rev_cl;
          retime_nxt = 1'b1;
          mode_nxt   = aim_mode(rev_cl, cur_r, MODE_DOWN);
        end else begin
          dir_nxt    = ~dir_r;
          tgt_nxt    = set_r;
          retime_nxt = 1'b1;
          mode_nxt   = aim_mode(set_r, cur_r, MODE_UP);
          run_nxt    = 1'b1;
        end
      end
      REQ_UP: begin
        spd_sel = clamp_speed(sum_inc);
        set_nxt = spd_sel;
        if (run_r) begin
          tgt_nxt    = spd_sel;
          retime_nxt = 1'b1;
          mode_nxt   = aim_mode(spd_sel, cur_r, MODE_UP);
        end
      end
      REQ_DOWN: begin
        spd_sel = ({1'b0, set_r} >= floor_sum) ? set_r - speed_inc_r : floor_spd;
        set_nxt = spd_sel;
        if (run_r) begin
          tgt_nxt    = spd_sel;
          retime_nxt = 1'b1;
          mode_nxt   = aim_mode(spd_sel, cur_r, MODE_DOWN);
        end
      end
      REQ_SET: begin
        spd_sel = clamp_speed({1'b0, new_speed});
        set_nxt = spd_sel;
        if (spd_sel == '0) begin
          tgt_nxt    = '0;
          retime_nxt = 1'b1;
          mode_nxt   = MODE_DOWN;
          rev_nxt    = 1'b0;
        end else begin
          tgt_nxt    = spd_sel;
          retime_nxt = 1'b1;
          mode_nxt   = aim_mode(spd_sel, cur_r, mode_r);
          run_nxt    = 1'b1;
        end
      end
      REQ_STOP, REQ_OFF, REQ_LONGPRESS: begin
        if (req_t'(req_type) != REQ_LONGPRESS ||
            (run_r && !(mode_r == MODE_DOWN && tgt_r == '0))) begin
          tgt_nxt    = '0;
          retime_nxt = 1'b1;
          mode_nxt   = MODE_DOWN;
          rev_nxt    = 1'b0;
        end
        if (req_t'(req_type) == REQ_OFF) begin
          run_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // steps left: distance / 5, or 1 when already there
  assign spd_gap    = (cur_r >= tgt_r) ? cur_r - tgt_r : tgt_r - cur_r;
  assign dist_prod  = {{DIV5_MUL_W{1'b0}}, spd_gap} * {{SPEED_W{1'b0}}, DIV5_MUL};
  assign steps_calc = (spd_gap == '0) ? STEP_W'(1) : dist_prod[DIV5_SHIFT +: STEP_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      cur_r     <= '0;
      tgt_r     <= '0;
      set_r     <= RST_INIT_SPEED;
      delay_r   <= '0;
      elapsed_r <= '0;
      rev_r     <= 1'b0;
      dir_r     <= 1'b0;
      run_r     <= 1'b0;
      retime_r  <= 1'b0;
    end else begin
      if (cmd.apply) begin
        mode_r    <= mode_nxt;
        cur_r     <= cur_nxt;
        tgt_r     <= tgt_nxt;
        set_r     <= set_nxt;
        elapsed_r <= elapsed_nxt;
        rev_r     <= rev_nxt;
        dir_r     <= dir_nxt;
        run_r     <= run_nxt;
        retime_r  <= retime_nxt;
      end
      if (cmd.delay_one) begin
        delay_r <= DUR_W'(1);
      end else if (div_done) begin
        delay_r <= div_quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_steps) begin
      steps_r <= steps_calc;
    end
    if (cmd.load_out) begin
      out_duty_r  <= duty_val;
      out_cw_r    <= dir_r;
      out_run_r   <= run_r;
      out_speed_r <= cur_r;
      out_mode_r  <= mode_r;
    end
  end

  msrr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (ramp_dur_r),
    .divisor  (steps_r),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

  msrr_duty u_duty (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.duty_start),
    .speed   (cur_r),
    .duty_lo (duty_min_r),
    .duty_hi (duty_max_r),
    .valid   (duty_valid),
    .duty    (duty_val)
  );

  assign sts.retime     = retime_r;
  assign sts.steps_zero = steps_r == '0;
  assign sts.div_busy   = div_busy | div_done;
  assign sts.duty_valid = duty_valid;

  assign out_duty      = out_duty_r;
  assign out_clockwise = out_cw_r;
  assign out_running   = out_run_r;
  assign out_speed_now = out_speed_r;
  assign out_ramp_mode = out_mode_r;

endmodule

// File: sv/msrr_ctrl.sv
// msrr_ctrl: sequencer for one beat: decode, step count, delay divide, duty, result load
// depends on msrr_pkg

module msrr_ctrl import msrr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LAUNCH,
    S_WAIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.apply = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.calc_steps = 1'b1;
        cmd.duty_start = 1'b1;
        state_nxt      = S_LAUNCH;
      end
      S_LAUNCH: begin
        if (sts.retime) begin
          cmd.delay_one = sts.steps_zero;
          cmd.div_start = !sts.steps_zero;
        end
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!sts.div_busy && sts.duty_valid) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= state_nxt == S_IDLE;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

// File: sv/motor_soft_ramp_reverse_controller_top.sv
// motor soft ramp reverse controller: one result beat per input beat, one beat in flight
// each beat passes through decode, step count and delay launch, then waits for the duty
// pipeline and, when the step delay is recomputed, the step-delay divider before the
// result load, which waits while the output is stalled; a new beat is taken after that load
// synchronous active-low reset restores register defaults and the idle, stopped state
// depends on msrr_pkg, msrr_chan_if, msrr_ctrl, msrr_dp

module motor_soft_ramp_reverse_controller_top import msrr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  msrr_in_if.sink    in_if,
  msrr_out_if.source out_if,
  msrr_cfg_if.sink   cfg_if
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_if.ready = 1'b1;

  msrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  msrr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (in_if.req_type),
    .new_speed     (in_if.new_speed),
    .cfg_we        (cfg_if.valid),
    .cfg_index     (cfg_if.index),
    .cfg_data      (cfg_if.data),
    .out_duty      (out_if.duty),
    .out_clockwise (out_if.clockwise),
    .out_running   (out_if.running),
    .out_speed_now (out_if.speed_now),
    .out_ramp_mode (out_if.ramp_mode)
  );

endmodule

// File: sv/msrr_checker.sv
// msrr_checker: port-level checks on the controller's result and input channels
// depends on msrr_pkg; bound to motor_soft_ramp_reverse_controller_top

module msrr_checker import msrr_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DUTY_W-1:0]  duty,
  input logic [SPEED_W-1:0] speed_now,
  input logic [MODE_W-1:0]  ramp_mode
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(speed_now)
                                && $stable(ramp_mode))
    else $error("result beat changed while stalled");

  // one beat in flight
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in flight");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> speed_now <= MAX_SPEED)
    else $error("speed above maximum");

  a_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && speed_now == '0 |-> duty == '0)
    else $error("nonzero duty at zero speed");

endmodule

bind motor_soft_ramp_reverse_controller_top msrr_checker u_msrr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .duty      (out_if.duty),
  .speed_now (out_if.speed_now),
  .ramp_mode (out_if.ramp_mode)
);

// File: verif/tb_motor_soft_ramp_reverse_controller_top.sv
// testbench for motor_soft_ramp_reverse_controller_top: directed then random commands and ticks
// a scoreboard class tracks ramp state and checks every status beat in order
// depends on msrr_pkg, msrr_chan_if and the controller rtl

module tb_motor_soft_ramp_reverse_controller_top import msrr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PHASES   = 14;
  localparam int PHASE_BEATS = 68;
  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = 25;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic               clockwise;
    logic               running;
    logic [SPEED_W-1:0] speed_now;
    logic [MODE_W-1:0]  ramp_mode;
  } motor_status_t;

  class motor_ramp_scoreboard;
    logic [DUR_W-1:0]   ramp_dur;
    logic [DUTY_W-1:0]  duty_lo, duty_hi;
    logic [SPEED_W-1:0] spd_inc, init_spd, rev_spd;

    mode_t              mode;
    logic [SPEED_W-1:0] cur, tgt, setting;
    logic [DUR_W-1:0]   delay, elapsed;
    bit                 rev_pend, cw, run;

    motor_status_t      status_q[$];
    int                 errors;

    function new();
      ramp_dur = RST_RAMP_DUR;
      duty_lo  = RST_DUTY_MIN;
      duty_hi  = RST_DUTY_MAX;
      spd_inc  = RST_SPEED_INC;
      init_spd = RST_INIT_SPEED;
      rev_spd  = RST_REV_SPEED;
      mode     = MODE_IDLE;
      cur      = '0;
      tgt      = '0;
      setting  = RST_INIT_SPEED;
      delay    = '0;
      elapsed  = '0;
      rev_pend = 0;
      cw       = 0;
      run      = 0;
      errors   = 0;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_RAMP_DUR:   ramp_dur = value[DUR_W-1:0];
        CFG_DUTY_MIN:   duty_lo  = value[DUTY_W-1:0];
        CFG_DUTY_MAX:   duty_hi  = value[DUTY_W-1:0];
        CFG_SPEED_INC:  spd_inc  = value[SPEED_W-1:0];
        CFG_INIT_SPEED: init_spd = value[SPEED_W-1:0];
        CFG_REV_SPEED:  rev_spd  = value[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [SPEED_W-1:0] limit_speed(int v);
      return (v > int'(MAX_SPEED)) ? MAX_SPEED : SPEED_W'(v);
    endfunction

    function void retime();
      int d, steps;
      d = (tgt > cur) ? int'(tgt) - int'(cur) : int'(cur) - int'(tgt);
      steps = (d > 0) ? d / int'(RAMP_STEP) : 1;
      delay = (steps > 0) ? DUR_W'(int'(ramp_dur) / steps) : DUR_W'(1);
    endfunction

    function void aim(logic [SPEED_W-1:0] target, mode_t mode_if_equal);
      tgt = target;
      retime();
      if (tgt > cur) mode = MODE_UP;
      else if (tgt < cur) mode = MODE_DOWN;
      else mode = mode_if_equal;
    endfunction

    function void halt();
      tgt = '0;
      retime();
      mode = MODE_DOWN;
      rev_pend = 0;
    endfunction

    function void begin_run();
      if (!run) begin
        aim(setting, MODE_UP);
        run = 1;
      end
    endfunction

    function void step_tick();
      int n;
      if (elapsed < ELAPSED_MAX) elapsed++;
      if (mode == MODE_IDLE || elapsed <= delay) return;
      elapsed = '0;
      if (mode == MODE_UP) begin
        n = int'(cur) + int'(RAMP_STEP);
        cur = (n < int'(tgt)) ? SPEED_W'(n) : tgt;
      end else begin
        cur = (int'(cur) > int'(tgt) + int'(RAMP_STEP)) ? cur - RAMP_STEP : tgt;
      end
      if (cur != tgt) return;
      if (rev_pend) begin
        cw = !cw;
        rev_pend = 0;
        run = 1;
        aim(setting, MODE_UP);
      end else begin
        mode = MODE_IDLE;
        if (cur == 0) begin
          run = 0;
          setting = limit_speed(int'(init_spd));
        end
      end
    endfunction

    function logic [DUTY_W-1:0] duty_of(logic [SPEED_W-1:0] s);
      int v;
      if (s == 0) return '0;
      v = (int'(s) - 1) * (int'(duty_hi) - int'(duty_lo)) / int'(DUTY_SPAN) + int'(duty_lo);
      return DUTY_W'(v);
    endfunction

    function void note_command(logic [REQ_W-1:0] req, logic [SPEED_W-1:0] ns);
      logic [SPEED_W-1:0] floor_spd;
      motor_status_t      st;
      floor_spd = limit_speed(int'(init_spd));
      case (req)
        REQ_TICK:  step_tick();
        REQ_START: begin_run();
        REQ_REVERSE: begin
          if (run) begin
            rev_pend = 1;
            aim(limit_speed(int'(rev_spd)), MODE_DOWN);
          end else begin
            cw = !cw;
            begin_run();
          end
        end
        REQ_UP: begin
          setting = limit_speed(int'(setting) + int'(spd_inc));
          if (run) aim(setting, MODE_UP);
        end
        REQ_DOWN: begin
          if (int'(setting) >= int'(spd_inc) + int'(floor_spd)) setting = setting - spd_inc;
          else setting = floor_spd;
          if (run) aim(setting, MODE_DOWN);
        end
        REQ_STOP: halt();
        REQ_SET: begin
          setting = limit_speed(int'(ns));
          if (setting == 0) begin
            halt();
          end else begin
            aim(setting, mode);
            run = 1;
          end
        end
        REQ_OFF: begin
          halt();
          run = 0;
        end
        REQ_LONGPRESS: begin
          if (run && !(mode == MODE_DOWN && tgt == 0)) halt();
        end
        default: ;
      endcase
      st.duty      = duty_of(cur);
      st.clockwise = cw;
      st.running   = run;
      st.speed_now = cur;
      st.ramp_mode = mode;
      status_q.push_back(st);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task check_status(motor_status_t got);
      motor_status_t want;
      if (status_q.size() == 0) begin
        report($sformatf("status beat with nothing expected: duty %0d cw %0d run %0d speed %0d mode %0d",
                         got.duty, got.clockwise, got.running, got.speed_now, got.ramp_mode));
        return;
      end
      want = status_q.pop_front();
      if (got !== want)
        report($sformatf("duty %0d/%0d cw %0d/%0d run %0d/%0d speed %0d/%0d mode %0d/%0d (got/exp)",
                         got.duty, want.duty, got.clockwise, want.clockwise,
                         got.running, want.running, got.speed_now, want.speed_now,
                         got.ramp_mode, want.ramp_mode));
    endtask

    task report_leftover();
      if (status_q.size() != 0)
        report($sformatf("%0d expected status beats never arrived", status_q.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;

  msrr_in_if  in_if();
  msrr_out_if out_if();
  msrr_cfg_if cfg_if();

  motor_soft_ramp_reverse_controller_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  motor_ramp_scoreboard sb = new();

  int tx_gap_pct;
  int rx_gap_pct;
  bit long_hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("motor_soft_ramp_reverse_controller_top verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_status(motor_status_t'{out_if.duty, out_if.clockwise, out_if.running,
                                      out_if.speed_now, out_if.ramp_mode});
  end

  initial begin : rx_side
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && long_hold_req) begin
        long_hold_req = 0;
        hold = LONG_HOLD;
      end else if (hold == 0 && rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
        hold = $urandom_range(1, 8);
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_command(logic [REQ_W-1:0] req, logic [SPEED_W-1:0] ns);
    int n;
    if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      n = $urandom_range(1, 8);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid     <= 1'b1;
    in_if.req_type  <= req;
    in_if.new_speed <= ns;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_command(req, ns);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic pick_command(output logic [REQ_W-1:0] req, output logic [SPEED_W-1:0] ns);
    int roll;
    roll = $urandom_range(0, 99);
    ns = SPEED_W'($urandom_range(0, 1023));
    if (roll < 12) req = REQ_TICK;
    else if (roll < 24) req = REQ_START;
    else if (roll < 34) req = REQ_REVERSE;
    else if (roll < 44) req = REQ_UP;
    else if (roll < 54) req = REQ_DOWN;
    else if (roll < 62) req = REQ_STOP;
    else if (roll < 78) req = REQ_SET;
    else if (roll < 83) req = REQ_OFF;
    else if (roll < 94) req = REQ_LONGPRESS;
    else req = REQ_W'(int'(REQ_LONGPRESS) + $urandom_range(1, 7));
    if (req == REQ_SET) begin
      case ($urandom_range(0, 9))
        0: ns = '0;
        1: ns = SPEED_W'($urandom_range(1001, 1023));
        2: ns = SPEED_W'($urandom_range(1, 4));
        default: ns = SPEED_W'($urandom_range(1, 1000));
      endcase
    end
  endtask

  task automatic configure_phase(int p);
    logic [CFG_DATA_W-1:0] v_dur, v_lo, v_hi, v_inc, v_init, v_rev;
    if (p == 1) begin
      v_dur = '0; v_lo = '0; v_hi = '0; v_inc = CFG_DATA_W'(1); v_init = '0; v_rev = '0;
    end else if (p == 2) begin
      v_dur = CFG_DATA_W'(10000); v_lo = CFG_DATA_W'(1023); v_hi = CFG_DATA_W'(1023);
      v_inc = CFG_DATA_W'(1000); v_init = CFG_DATA_W'(1023); v_rev = CFG_DATA_W'(1023);
    end else if (p == 3) begin
      v_dur = CFG_DATA_W'($urandom_range(0, 60)); v_lo = CFG_DATA_W'(1023); v_hi = '0;
      v_inc = CFG_DATA_W'($urandom_range(1, 200));
      v_init = CFG_DATA_W'($urandom_range(0, 500));
      v_rev = CFG_DATA_W'($urandom_range(0, 500));
    end else begin
      v_dur = (p % 5 == 0) ? CFG_DATA_W'($urandom_range(0, 10000))
                           : CFG_DATA_W'($urandom_range(0, 300));
      v_lo  = CFG_DATA_W'($urandom_range(0, 1023));
      v_hi  = CFG_DATA_W'($urandom_range(0, 1023));
      v_inc = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(1, 1000))
                                          : CFG_DATA_W'($urandom_range(1, 100));
      v_init = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(1001, 1023))
                                           : CFG_DATA_W'($urandom_range(0, 1000));
      v_rev  = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(1001, 1023))
                                           : CFG_DATA_W'($urandom_range(0, 1000));
    end
    write_register(CFG_RAMP_DUR, v_dur);
    write_register(CFG_DUTY_MIN, v_lo);
    write_register(CFG_DUTY_MAX, v_hi);
    write_register(CFG_SPEED_INC, v_inc);
    write_register(CFG_INIT_SPEED, v_init);
    write_register(CFG_REV_SPEED, v_rev);
  endtask

  task automatic run_random(int count, bool_pause);
    logic [REQ_W-1:0]   req;
    logic [SPEED_W-1:0] ns;
    int sent, ticks;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < count) begin
      pick_command(req, ns);
      send_command(req, ns);
      sent++;
      if ($urandom_range(0, 9) < 6) begin
        ticks = $urandom_range(3, 40);
        repeat (ticks) send_command(REQ_TICK, SPEED_W'($urandom_range(0, 1023)));
        sent += ticks;
      end
      // when bool_pause is set, the sender waits out every outstanding status beat once mid-phase
      if (bool_pause && !paused && sent >= count / 2) begin
        paused = 1;
        drain();
      end
    end
  endtask

  initial begin : stimulus
    int settle_cnt;
    logic [REQ_W-1:0] unk_lo, unk_hi;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_TICK;
    in_if.new_speed = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_RAMP_DUR;
    cfg_if.data = '0;
    tx_gap_pct = 25;
    rx_gap_pct = 25;
    long_hold_req = 0;
    unk_lo = REQ_W'(int'(REQ_LONGPRESS) + 1);
    unk_hi = {REQ_W{1'b1}};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pass at reset defaults
    send_command(REQ_TICK, '0);
    send_command(REQ_LONGPRESS, '0);
    send_command(REQ_REVERSE, '0);
    send_command(REQ_START, '0);
    send_command(REQ_UP, '0);
    send_command(REQ_DOWN, '0);
    send_command(REQ_DOWN, {SPEED_W{1'b1}});
    send_command(unk_lo, '0);
    send_command(REQ_SET, {SPEED_W{1'b1}});
    send_command(REQ_LONGPRESS, '0);
    send_command(REQ_LONGPRESS, '0);
    send_command(REQ_SET, '0);
    send_command(REQ_OFF, '0);
    send_command(REQ_TICK, {SPEED_W{1'b1}});
    send_command(REQ_SET, SPEED_W'(3));
    send_command(REQ_TICK, '0);
    send_command(REQ_TICK, '0);
    send_command(REQ_TICK, '0);
    send_command(REQ_SET, SPEED_W'(3));
    send_command(REQ_REVERSE, '0);
    send_command(REQ_STOP, '0);
    send_command(unk_hi, {SPEED_W{1'b1}});
    send_command(REQ_START, '0);
    send_command(REQ_OFF, '0);

    for (int p = 1; p <= N_PHASES; p++) begin
      drain();
      repeat (SETTLE) @(posedge clk);
      configure_phase(p);
      if (p == N_PHASES) begin
        tx_gap_pct = 0;
        rx_gap_pct = 0;
      end else if (p % 3 == 0) begin
        tx_gap_pct = 0;
        rx_gap_pct = 0;
      end else begin
        tx_gap_pct = $urandom_range(10, 50);
        rx_gap_pct = $urandom_range(10, 50);
      end
      if (p == 5) long_hold_req = 1;
      run_random(PHASE_BEATS, p == 7);
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    settle_cnt = 0;
    while (sb.pending() != 0 && settle_cnt < 5000) begin
      @(posedge clk);
      settle_cnt++;
    end
    repeat (SETTLE) @(posedge clk);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("motor_soft_ramp_reverse_controller_top verification clean");
    end else begin
      $display("motor_soft_ramp_reverse_controller_top verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/msrr_pkg.sv
sv/msrr_chan_if.sv
sv/msrr_div.sv
sv/msrr_duty.sv
sv/msrr_dp.sv
sv/msrr_ctrl.sv
sv/motor_soft_ramp_reverse_controller_top.sv
sv/msrr_checker.sv
verif/tb_motor_soft_ramp_reverse_controller_top.sv
